// File: hw/rtl/ppc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_pkg
// Types, constants and arithmetic helpers shared by the disc-pair collision
// pipeline.
// ----------------------------------------------------------------------------
package ppc_pkg;

   // field and datapath widths
   localparam int FIELD_W = 24;
   localparam int DIFF_W  = 25;
   localparam int MAG_W   = 17;
   localparam int SQ_W    = 34;
   localparam int DIST_W  = 17;
   localparam int NORM_W  = 17;
   localparam int CSR_W   = 16;
   localparam int SQRT_STEPS = DIST_W;
   localparam int DIV_STEPS  = NORM_W;

   // register indexes
   localparam logic CSR_RADIUS  = 1'b0;
   localparam logic CSR_DAMPING = 1'b1;

   // reset values of the registers
   localparam logic [CSR_W-1:0] RADIUS_RESET  = 16'd1280;
   localparam logic [CSR_W-1:0] DAMPING_RESET = 16'd52429;

   // saturation limits
   localparam logic signed [39:0] SAT_MAX = 40'sd8388607;
   localparam logic signed [39:0] SAT_MIN = -40'sd8388608;

   typedef struct packed {
      logic signed [FIELD_W-1:0] a_pos_x;
      logic signed [FIELD_W-1:0] a_pos_y;
      logic signed [FIELD_W-1:0] a_vel_x;
      logic signed [FIELD_W-1:0] a_vel_y;
      logic signed [FIELD_W-1:0] b_pos_x;
      logic signed [FIELD_W-1:0] b_pos_y;
      logic signed [FIELD_W-1:0] b_vel_x;
      logic signed [FIELD_W-1:0] b_vel_y;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] a_new_pos_x;
      logic signed [FIELD_W-1:0] a_new_pos_y;
      logic signed [FIELD_W-1:0] a_new_vel_x;
      logic signed [FIELD_W-1:0] a_new_vel_y;
      logic signed [FIELD_W-1:0] b_new_pos_x;
      logic signed [FIELD_W-1:0] b_new_pos_y;
      logic signed [FIELD_W-1:0] b_new_vel_x;
      logic signed [FIELD_W-1:0] b_new_vel_y;
      logic                      touched;
   } rsp_type;

   // per-item context carried down the pipeline
   typedef struct packed {
      req_type          item;
      logic             touch;
      logic             dx_neg;
      logic             dy_neg;
      logic [MAG_W-1:0] dx_mag;
      logic [MAG_W-1:0] dy_mag;
   } ctx_type;

   typedef struct packed {
      logic            valid;
      ctx_type         ctx;
      logic [SQ_W-1:0] dist_sq;
   } front_out_type;

   typedef struct packed {
      logic              valid;
      ctx_type           ctx;
      logic [DIST_W-1:0] distance;
   } sqrt_out_type;

   typedef struct packed {
      logic              valid;
      ctx_type           ctx;
      logic [DIST_W-1:0] distance;
      logic [NORM_W-1:0] nx_mag;
      logic [NORM_W-1:0] ny_mag;
   } div_out_type;

   // shift right rounding half away from zero, sh is a constant at each use
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
      logic [63:0] m;
      m = v[63] ? (64'd0 - v) : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? $signed(64'd0 - m) : $signed(m);
   endfunction

   // clamp to the field range
   function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [39:0] v);
      logic signed [39:0] c;
      if (v > SAT_MAX) begin
         c = SAT_MAX;
      end else if (v < SAT_MIN) begin
         c = SAT_MIN;
      end else begin
         c = v;
      end
      return c[FIELD_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/particle_pair_collision_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pair_collision_top
// Collision response for a pair of equal-radius discs.
// ----------------------------------------------------------------------------
// Each item on the req_ channel carries two discs (position and velocity,
// signed Q16.8). If the discs overlap they are pushed apart along the normal
// and a damped normal impulse is exchanged; one result item leaves on the
// rsp_ channel for every item, with touched set when the discs overlapped.
// The csr_ port writes the disc radius (index 0) and damping (index 1); the
// user must write it only while the pipeline is empty, which the block itself
// does not enforce. The pipeline stages are 4 for distance and overlap test,
// 17 for the square root (one root bit per stage), 17 for the normal divider
// (one quotient bit per stage) and 8 for products, rounding and the output
// register. Throughput is one item per cycle unless the receiver stalls.
// Reset empties the pipeline and loads radius 5.0 and damping about 0.8.
// While the receiver stalls a valid result, the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module particle_pair_collision_top import ppc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_item,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   logic [CSR_W-1:0] radius_ff, damping_ff;
   logic [MAG_W-1:0] rsum;
   logic             en;
   front_out_type    front_out;
   sqrt_out_type     sqrt_out;
   div_out_type      div_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RESET;
         damping_ff <= DAMPING_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS:  radius_ff  <= csr_wdata;
            CSR_DAMPING: damping_ff <= csr_wdata;
            default:     radius_ff  <= radius_ff;
         endcase
      end
   end

   assign rsum = {radius_ff, 1'b0};

   // pipeline advances unless a result is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   ppc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_item  (req_item),
      .rsum     (rsum),
      .out      (front_out)
   );

   ppc_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (front_out),
      .out   (sqrt_out)
   );

   ppc_div u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (sqrt_out),
      .out   (div_out)
   );

   ppc_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in        (div_out),
      .rsum      (rsum),
      .damping   (damping_ff),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

endmodule
`default_nettype wire

// File: hw/rtl/ppc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_front
// Center difference, squared distance and overlap test in four stages.
// ----------------------------------------------------------------------------
module ppc_front import ppc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire req_type             in_item,
   input  wire logic [MAG_W-1:0]    rsum,
   output front_out_type            out
);

   // stage 1: differences
   logic                      s1_vld_ff;
   req_type                   s1_item_ff;
   logic signed [DIFF_W-1:0]  s1_dx_ff, s1_dy_ff;
   logic signed [DIFF_W-1:0]  s1_dx_in, s1_dy_in;

   assign s1_dx_in = DIFF_W'(in_item.b_pos_x) - DIFF_W'(in_item.a_pos_x);
   assign s1_dy_in = DIFF_W'(in_item.b_pos_y) - DIFF_W'(in_item.a_pos_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff <= in_item;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
      end
   end

   // stage 2: magnitudes and coarse range check
   logic              s2_vld_ff;
   req_type           s2_item_ff;
   logic              s2_near_ff, s2_xneg_ff, s2_yneg_ff;
   logic [MAG_W-1:0]  s2_xmag_ff, s2_ymag_ff;
   logic [DIFF_W-1:0] s2_xabs_in, s2_yabs_in;
   logic              s2_near_in;

   assign s2_xabs_in = s1_dx_ff[DIFF_W-1] ? (DIFF_W'(0) - s1_dx_ff) : s1_dx_ff;
   assign s2_yabs_in = s1_dy_ff[DIFF_W-1] ? (DIFF_W'(0) - s1_dy_ff) : s1_dy_ff;
   assign s2_near_in = (s2_xabs_in < DIFF_W'(rsum)) && (s2_yabs_in < DIFF_W'(rsum));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_item_ff <= s1_item_ff;
         s2_near_ff <= s2_near_in;
         s2_xneg_ff <= s1_dx_ff[DIFF_W-1];
         s2_yneg_ff <= s1_dy_ff[DIFF_W-1];
         s2_xmag_ff <= s2_xabs_in[MAG_W-1:0];
         s2_ymag_ff <= s2_yabs_in[MAG_W-1:0];
      end
   end

   // stage 3: squares
   logic            s3_vld_ff;
   ctx_type         s3_ctx_ff;
   logic            s3_near_ff;
   logic [SQ_W-1:0] s3_sqx_ff, s3_sqy_ff, s3_rsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ctx_ff.item   <= s2_item_ff;
         s3_ctx_ff.touch  <= 1'b0;
         s3_ctx_ff.dx_neg <= s2_xneg_ff;
         s3_ctx_ff.dy_neg <= s2_yneg_ff;
         s3_ctx_ff.dx_mag <= s2_xmag_ff;
         s3_ctx_ff.dy_mag <= s2_ymag_ff;
         s3_near_ff       <= s2_near_ff;
         s3_sqx_ff        <= SQ_W'(s2_xmag_ff) * SQ_W'(s2_xmag_ff);
         s3_sqy_ff        <= SQ_W'(s2_ymag_ff) * SQ_W'(s2_ymag_ff);
         s3_rsq_ff        <= SQ_W'(rsum) * SQ_W'(rsum);
      end
   end

   // stage 4: sum and overlap test
   logic            s4_vld_ff;
   ctx_type         s4_ctx_ff;
   ctx_type         s4_ctx_in;
   logic [SQ_W-1:0] s4_dsq_ff;
   logic [SQ_W:0]   s4_sum_in;
   logic            s4_touch_in;

   assign s4_sum_in   = {1'b0, s3_sqx_ff} + {1'b0, s3_sqy_ff};
   assign s4_touch_in = s3_near_ff && (s4_sum_in < {1'b0, s3_rsq_ff});

   always_comb begin
      s4_ctx_in       = s3_ctx_ff;
      s4_ctx_in.touch = s4_touch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ctx_ff <= s4_ctx_in;
         s4_dsq_ff <= s4_sum_in[SQ_W-1:0];
      end
   end

   assign out.valid   = s4_vld_ff;
   assign out.ctx     = s4_ctx_ff;
   assign out.dist_sq = s4_dsq_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ppc_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ppc_isqrt import ppc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire front_out_type in,
   output sqrt_out_type       out
);

   logic              vld_ff  [SQRT_STEPS];
   ctx_type           ctx_ff  [SQRT_STEPS];
   logic [SQ_W-1:0]   rem_ff  [SQRT_STEPS];
   logic [DIST_W-1:0] root_ff [SQRT_STEPS];

   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
      localparam int J = SQRT_STEPS - 1 - s;
      logic              vld_src;
      ctx_type           ctx_src;
      logic [SQ_W-1:0]   rem_src;
      logic [DIST_W-1:0] root_src;
      logic [SQ_W:0]     trial;
      logic [SQ_W-1:0]   rem_in;
      logic [DIST_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign vld_src  = in.valid;
         assign ctx_src  = in.ctx;
         assign rem_src  = in.dist_sq;
         assign root_src = '0;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign ctx_src  = ctx_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
      end

      // try setting this root bit
      always_comb begin
         trial = ((SQ_W+1)'(root_src) << (J + 1)) | ((SQ_W+1)'(1) << (2 * J));
         if ({1'b0, rem_src} >= trial) begin
            rem_in  = rem_src - trial[SQ_W-1:0];
            root_in = root_src | (DIST_W'(1) << J);
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctx_ff[s]  <= ctx_src;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   // coincident centers use the smallest nonzero distance
   assign out.valid    = vld_ff[SQRT_STEPS-1];
   assign out.ctx      = ctx_ff[SQRT_STEPS-1];
   assign out.distance = (root_ff[SQRT_STEPS-1] == '0) ? DIST_W'(1) : root_ff[SQRT_STEPS-1];

endmodule
`default_nettype wire

// File: hw/rtl/ppc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_div
// Pipelined restoring divider for both normal components, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module ppc_div import ppc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire sqrt_out_type in,
   output div_out_type       out
);

   localparam int REM_W = MAG_W + 16;

   logic              vld_ff [DIV_STEPS];
   ctx_type           ctx_ff [DIV_STEPS];
   logic [DIST_W-1:0] dst_ff [DIV_STEPS];
   logic [REM_W-1:0]  rx_ff  [DIV_STEPS];
   logic [REM_W-1:0]  ry_ff  [DIV_STEPS];
   logic [NORM_W-1:0] qx_ff  [DIV_STEPS];
   logic [NORM_W-1:0] qy_ff  [DIV_STEPS];

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      localparam int J = DIV_STEPS - 1 - s;
      logic              vld_src;
      ctx_type           ctx_src;
      logic [DIST_W-1:0] dst_src;
      logic [REM_W-1:0]  rx_src, ry_src;
      logic [NORM_W-1:0] qx_src, qy_src;
      logic [REM_W:0]    den;
      logic [REM_W-1:0]  rx_in, ry_in;
      logic [NORM_W-1:0] qx_in, qy_in;

      if (s == 0) begin : g_first
         assign vld_src = in.valid;
         assign ctx_src = in.ctx;
         assign dst_src = in.distance;
         assign rx_src  = {in.ctx.dx_mag, 16'd0};
         assign ry_src  = {in.ctx.dy_mag, 16'd0};
         assign qx_src  = '0;
         assign qy_src  = '0;
      end else begin : g_next
         assign vld_src = vld_ff[s-1];
         assign ctx_src = ctx_ff[s-1];
         assign dst_src = dst_ff[s-1];
         assign rx_src  = rx_ff[s-1];
         assign ry_src  = ry_ff[s-1];
         assign qx_src  = qx_ff[s-1];
         assign qy_src  = qy_ff[s-1];
      end

      // compare against the shifted divisor and subtract
      always_comb begin
         den = (REM_W+1)'(dst_src) << J;
         if ({1'b0, rx_src} >= den) begin
            rx_in = rx_src - den[REM_W-1:0];
            qx_in = qx_src | (NORM_W'(1) << J);
         end else begin
            rx_in = rx_src;
            qx_in = qx_src;
         end
         if ({1'b0, ry_src} >= den) begin
            ry_in = ry_src - den[REM_W-1:0];
            qy_in = qy_src | (NORM_W'(1) << J);
         end else begin
            ry_in = ry_src;
            qy_in = qy_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctx_ff[s] <= ctx_src;
            dst_ff[s] <= dst_src;
            rx_ff[s]  <= rx_in;
            ry_ff[s]  <= ry_in;
            qx_ff[s]  <= qx_in;
            qy_ff[s]  <= qy_in;
         end
      end
   end

   assign out.valid    = vld_ff[DIV_STEPS-1];
   assign out.ctx      = ctx_ff[DIV_STEPS-1];
   assign out.distance = dst_ff[DIV_STEPS-1];
   assign out.nx_mag   = qx_ff[DIV_STEPS-1];
   assign out.ny_mag   = qy_ff[DIV_STEPS-1];

endmodule
`default_nettype wire

// File: hw/rtl/ppc_resp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_resp
// Separation shift and damped impulse: products, rounding, saturation and the
// output register, in eight stages.
// ----------------------------------------------------------------------------
module ppc_resp import ppc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire div_out_type      in,
   input  wire logic [MAG_W-1:0] rsum,
   input  wire logic [CSR_W-1:0] damping,
   output logic                  out_valid,
   output rsp_type               out_item
);

   localparam int N_W  = NORM_W + 1;
   localparam int P_W  = 2 * N_W;
   localparam int K_W  = DIFF_W + N_W;
   localparam int KS_W = K_W + 1;
   localparam int S_W  = 19;
   localparam int KR_W = 28;
   localparam int KN_W = KR_W + N_W;
   localparam int PD_W = KN_W + CSR_W + 1;
   localparam int I_W  = 32;

   // stage 1: signed normal, overlap, velocity difference
   logic                     r1_vld_ff;
   req_type                  r1_item_ff;
   logic                     r1_touch_ff;
   logic signed [N_W-1:0]    r1_nx_ff, r1_ny_ff;
   logic signed [N_W-1:0]    r1_ovl_ff;
   logic signed [DIFF_W-1:0] r1_dvx_ff, r1_dvy_ff;
   logic signed [N_W-1:0]    r1_nx_in, r1_ny_in;
   logic [MAG_W-1:0]         r1_ovl_in;

   assign r1_nx_in  = in.ctx.dx_neg ? (N_W'(0) - N_W'(in.nx_mag)) : N_W'(in.nx_mag);
   assign r1_ny_in  = in.ctx.dy_neg ? (N_W'(0) - N_W'(in.ny_mag)) : N_W'(in.ny_mag);
   assign r1_ovl_in = rsum - in.distance;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_vld_ff <= 1'b0;
      end else if (en) begin
         r1_vld_ff <= in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_item_ff  <= in.ctx.item;
         r1_touch_ff <= in.ctx.touch;
         r1_nx_ff    <= r1_nx_in;
         r1_ny_ff    <= r1_ny_in;
         r1_ovl_ff   <= $signed({1'b0, r1_ovl_in});
         r1_dvx_ff   <= DIFF_W'(in.ctx.item.b_vel_x) - DIFF_W'(in.ctx.item.a_vel_x);
         r1_dvy_ff   <= DIFF_W'(in.ctx.item.b_vel_y) - DIFF_W'(in.ctx.item.a_vel_y);
      end
   end

   // stage 2: products
   logic                  r2_vld_ff;
   req_type               r2_item_ff;
   logic                  r2_touch_ff;
   logic signed [N_W-1:0] r2_nx_ff, r2_ny_ff;
   logic signed [P_W-1:0] r2_px_ff, r2_py_ff;
   logic signed [K_W-1:0] r2_kx_ff, r2_ky_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_vld_ff <= 1'b0;
      end else if (en) begin
         r2_vld_ff <= r1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_item_ff  <= r1_item_ff;
         r2_touch_ff <= r1_touch_ff;
         r2_nx_ff    <= r1_nx_ff;
         r2_ny_ff    <= r1_ny_ff;
         r2_px_ff    <= P_W'(r1_ovl_ff) * P_W'(r1_nx_ff);
         r2_py_ff    <= P_W'(r1_ovl_ff) * P_W'(r1_ny_ff);
         r2_kx_ff    <= K_W'(r1_dvx_ff) * K_W'(r1_nx_ff);
         r2_ky_ff    <= K_W'(r1_dvy_ff) * K_W'(r1_ny_ff);
      end
   end

   // stage 3: round the shift, sum the normal velocity
   logic                   r3_vld_ff;
   req_type                r3_item_ff;
   logic                   r3_touch_ff;
   logic signed [N_W-1:0]  r3_nx_ff, r3_ny_ff;
   logic signed [S_W-1:0]  r3_sx_ff, r3_sy_ff;
   logic signed [KS_W-1:0] r3_ks_ff;
   logic signed [63:0]     r3_sx_in, r3_sy_in;

   assign r3_sx_in = round_shift(64'(r2_px_ff), 17);
   assign r3_sy_in = round_shift(64'(r2_py_ff), 17);

   always_ff @(posedge clock) begin
      if (reset) begin
         r3_vld_ff <= 1'b0;
      end else if (en) begin
         r3_vld_ff <= r2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r3_item_ff  <= r2_item_ff;
         r3_touch_ff <= r2_touch_ff;
         r3_nx_ff    <= r2_nx_ff;
         r3_ny_ff    <= r2_ny_ff;
         r3_sx_ff    <= r3_sx_in[S_W-1:0];
         r3_sy_ff    <= r3_sy_in[S_W-1:0];
         r3_ks_ff    <= KS_W'(r2_kx_ff) + KS_W'(r2_ky_ff);
      end
   end

   // stage 4: round k, update positions
   logic                   r4_vld_ff;
   req_type                r4_item_ff;
   logic                   r4_touch_ff;
   logic signed [N_W-1:0]  r4_nx_ff, r4_ny_ff;
   logic signed [KR_W-1:0] r4_k_ff;
   logic signed [63:0]     r4_k_in;
   req_type                r4_item_in;

   assign r4_k_in = round_shift(64'(r3_ks_ff), 16);

   always_comb begin
      r4_item_in = r3_item_ff;
      if (r3_touch_ff) begin
         r4_item_in.a_pos_x = sat_field(40'(r3_item_ff.a_pos_x) - 40'(r3_sx_ff));
         r4_item_in.a_pos_y = sat_field(40'(r3_item_ff.a_pos_y) - 40'(r3_sy_ff));
         r4_item_in.b_pos_x = sat_field(40'(r3_item_ff.b_pos_x) + 40'(r3_sx_ff));
         r4_item_in.b_pos_y = sat_field(40'(r3_item_ff.b_pos_y) + 40'(r3_sy_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r4_vld_ff <= 1'b0;
      end else if (en) begin
         r4_vld_ff <= r3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r4_item_ff  <= r4_item_in;
         r4_touch_ff <= r3_touch_ff;
         r4_nx_ff    <= r3_nx_ff;
         r4_ny_ff    <= r3_ny_ff;
         r4_k_ff     <= r4_k_in[KR_W-1:0];
      end
   end

   // stage 5: k times normal
   logic                   r5_vld_ff;
   req_type                r5_item_ff;
   logic                   r5_touch_ff;
   logic signed [KN_W-1:0] r5_knx_ff, r5_kny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r5_vld_ff <= 1'b0;
      end else if (en) begin
         r5_vld_ff <= r4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r5_item_ff  <= r4_item_ff;
         r5_touch_ff <= r4_touch_ff;
         r5_knx_ff   <= KN_W'(r4_k_ff) * KN_W'(r4_nx_ff);
         r5_kny_ff   <= KN_W'(r4_k_ff) * KN_W'(r4_ny_ff);
      end
   end

   // stage 6: damping
   logic                    r6_vld_ff;
   req_type                 r6_item_ff;
   logic                    r6_touch_ff;
   logic signed [PD_W-1:0]  r6_pdx_ff, r6_pdy_ff;
   logic signed [CSR_W:0]   r6_damp_in;

   assign r6_damp_in = $signed({1'b0, damping});

   always_ff @(posedge clock) begin
      if (reset) begin
         r6_vld_ff <= 1'b0;
      end else if (en) begin
         r6_vld_ff <= r5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r6_item_ff  <= r5_item_ff;
         r6_touch_ff <= r5_touch_ff;
         r6_pdx_ff   <= PD_W'(r5_knx_ff) * PD_W'(r6_damp_in);
         r6_pdy_ff   <= PD_W'(r5_kny_ff) * PD_W'(r6_damp_in);
      end
   end

   // stage 7: round the impulse
   logic                  r7_vld_ff;
   req_type               r7_item_ff;
   logic                  r7_touch_ff;
   logic signed [I_W-1:0] r7_ix_ff, r7_iy_ff;
   logic signed [63:0]    r7_ix_in, r7_iy_in;

   assign r7_ix_in = round_shift(64'(r6_pdx_ff), 32);
   assign r7_iy_in = round_shift(64'(r6_pdy_ff), 32);

   always_ff @(posedge clock) begin
      if (reset) begin
         r7_vld_ff <= 1'b0;
      end else if (en) begin
         r7_vld_ff <= r6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r7_item_ff  <= r6_item_ff;
         r7_touch_ff <= r6_touch_ff;
         r7_ix_ff    <= r7_ix_in[I_W-1:0];
         r7_iy_ff    <= r7_iy_in[I_W-1:0];
      end
   end

   // stage 8: velocity update into the output register
   logic    r8_vld_ff;
   rsp_type r8_item_ff;
   rsp_type r8_item_in;

   always_comb begin
      r8_item_in.a_new_pos_x = r7_item_ff.a_pos_x;
      r8_item_in.a_new_pos_y = r7_item_ff.a_pos_y;
      r8_item_in.b_new_pos_x = r7_item_ff.b_pos_x;
      r8_item_in.b_new_pos_y = r7_item_ff.b_pos_y;
      r8_item_in.a_new_vel_x = r7_item_ff.a_vel_x;
      r8_item_in.a_new_vel_y = r7_item_ff.a_vel_y;
      r8_item_in.b_new_vel_x = r7_item_ff.b_vel_x;
      r8_item_in.b_new_vel_y = r7_item_ff.b_vel_y;
      r8_item_in.touched     = r7_touch_ff;
      if (r7_touch_ff) begin
         r8_item_in.a_new_vel_x = sat_field(40'(r7_item_ff.a_vel_x) + 40'(r7_ix_ff));
         r8_item_in.a_new_vel_y = sat_field(40'(r7_item_ff.a_vel_y) + 40'(r7_iy_ff));
         r8_item_in.b_new_vel_x = sat_field(40'(r7_item_ff.b_vel_x) - 40'(r7_ix_ff));
         r8_item_in.b_new_vel_y = sat_field(40'(r7_item_ff.b_vel_y) - 40'(r7_iy_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r8_vld_ff <= 1'b0;
      end else if (en) begin
         r8_vld_ff <= r7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r8_item_ff <= r8_item_in;
      end
   end

   assign out_valid = r8_vld_ff;
   assign out_item  = r8_item_ff;

endmodule
`default_nettype wire
